### hw/rtl/sog_pkg.sv
// shared types, constants and sine table generator for the glide oscillator
`timescale 1ns / 1ps

package sog_pkg;

  // field and state widths
  localparam int TGT_W     = 24;  // target frequency, signed, 8 fraction bits
  localparam int COEFF_W   = 24;  // glide coefficient, unsigned Q0.24
  localparam int FREQ_W    = 40;  // smoothed frequency, signed, 24 fraction bits
  localparam int FREQ_FRAC = 24;
  localparam int TGT_SHIFT = 16;  // target fraction bits widened from 8 to 24
  localparam int DIFF_W    = FREQ_W + 1;

  localparam logic [COEFF_W-1:0] COEFF_RESET = 24'd16759749;

  // divide by 48000 = 128 * 375: shift, then radix-256 long division by 375
  localparam int PRESHIFT = 7;
  localparam int ODD_DIV  = 375;
  localparam int DIGIT_W  = 8;
  localparam int REM_W    = 9;

  // cordic for the sine table
  localparam int     CORDIC_STEPS = 31;
  localparam longint CORDIC_K     = 64'sd652032874;
  localparam longint TURN_HALF    = 64'sh0000_0000_8000_0000;
  localparam longint TURN_QUARTER = 64'sh0000_0000_4000_0000;
  localparam longint ROUND_HALF   = 64'sh0000_0000_2000_0000;

  localparam longint ARC_TAB [CORDIC_STEPS] = '{
    64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756, 64'sd42667331,
    64'sd21354465, 64'sd10679838, 64'sd5340245, 64'sd2670163, 64'sd1335087,
    64'sd667544, 64'sd333772, 64'sd166886, 64'sd83443, 64'sd41722, 64'sd20861,
    64'sd10430, 64'sd5215, 64'sd2608, 64'sd1304, 64'sd652, 64'sd326, 64'sd163,
    64'sd81, 64'sd41, 64'sd20, 64'sd10, 64'sd5, 64'sd3, 64'sd1, 64'sd1
  };

  // controller to datapath
  typedef struct packed {
    logic load;
    logic diff;
    logic rd_e0;
    logic rd_e1;
    logic mul_hi;
    logic mul_lo;
    logic emit;
    logic div_load;
    logic div_step;
    logic phase_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic div_last;
  } status_t;

  // one sine table entry, evaluated at elaboration
  function automatic longint sine_entry(int k, int addr_bits, int out_bits);
    longint a;
    longint s;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint mag;
    longint amp;
    longint v;
    a = (longint'(k) << (32 - addr_bits)) & 64'sh0000_0000_FFFF_FFFF;
    s = (a >= TURN_HALF) ? a - (TURN_HALF + TURN_HALF) : a;
    if (s > TURN_QUARTER) begin
      s = TURN_HALF - s;
    end else if (s < -TURN_QUARTER) begin
      s = -TURN_HALF - s;
    end
    x = CORDIC_K;
    y = 0;
    z = s;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARC_TAB[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARC_TAB[i];
      end
    end
    mag = (y < 0) ? -y : y;
    amp = (64'sd1 <<< (out_bits - 1)) - 64'sd1;
    v = (mag * amp + ROUND_HALF) >>> 30;
    if (v > amp) begin
      v = amp;
    end
    return (y < 0) ? -v : v;
  endfunction

endpackage

### hw/rtl/sog_stream_if.sv
// valid/ready stream interfaces for the oscillator input and sample output
`timescale 1ns / 1ps

interface sog_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [sog_pkg::TGT_W-1:0]   target_freq;
  logic                               phase_reset;

  modport source (output valid, output target_freq, output phase_reset, input ready);
  modport sink (input valid, input target_freq, input phase_reset, output ready);
endinterface

interface sog_out_if #(
  parameter int OUT_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

### hw/rtl/sog_ctrl.sv
// sequencing state machine for the glide oscillator
`timescale 1ns / 1ps

module sog_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  sog_pkg::status_t status,
  output logic             in_ready,
  output sog_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_MULHI,
    S_MULLO,
    S_EMIT,
    S_DLOAD,
    S_DIV,
    S_PHASE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ready && in_valid) begin
            state    <= S_DIFF;
            in_ready <= 1'b0;
          end else begin
            in_ready <= 1'b1;
          end
        end
        S_DIFF:  state <= S_MULHI;
        S_MULHI: state <= S_MULLO;
        S_MULLO: state <= S_EMIT;
        S_EMIT: begin
          if (status.slot_free) begin
            state <= S_DLOAD;
          end
        end
        S_DLOAD: state <= S_DIV;
        S_DIV: begin
          if (status.div_last) begin
            state <= S_PHASE;
          end
        end
        S_PHASE: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.load = in_ready && in_valid;
      S_DIFF: begin
        cmd.diff  = 1'b1;
        cmd.rd_e0 = 1'b1;
      end
      S_MULHI: begin
        cmd.mul_hi = 1'b1;
        cmd.rd_e1  = 1'b1;
      end
      S_MULLO: cmd.mul_lo     = 1'b1;
      S_EMIT:  cmd.emit       = status.slot_free;
      S_DLOAD: cmd.div_load   = 1'b1;
      S_DIV:   cmd.div_step   = 1'b1;
      S_PHASE: cmd.phase_step = 1'b1;
    endcase
  end

endmodule

### hw/rtl/sog_datapath.sv
// glide, sine table, interpolation, increment divider and phase accumulator
`timescale 1ns / 1ps

module sog_datapath #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int OUT_BITS        = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [sog_pkg::COEFF_W-1:0]      cfg_wr_data,
  input  logic signed [sog_pkg::TGT_W-1:0] target_freq,
  input  logic                             phase_reset,
  input  sog_pkg::cmd_t                    cmd,
  output sog_pkg::status_t                 status,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [OUT_BITS-1:0]       sample
);

  localparam int COEFF_W    = sog_pkg::COEFF_W;
  localparam int FREQ_W     = sog_pkg::FREQ_W;
  localparam int DIFF_W     = sog_pkg::DIFF_W;
  localparam int TGT_W      = sog_pkg::TGT_W;
  localparam int TGT_SHIFT  = sog_pkg::TGT_SHIFT;
  localparam int DIGIT_W    = sog_pkg::DIGIT_W;
  localparam int REM_W      = sog_pkg::REM_W;
  localparam int DEPTH      = 2 ** TABLE_ADDR_BITS;
  localparam int ADDR_SHIFT = PHASE_BITS - TABLE_ADDR_BITS;
  localparam int FRAC_BITS  = (ADDR_SHIFT < 16) ? ADDR_SHIFT : 16;
  localparam int INC_UP     = (PHASE_BITS >= sog_pkg::FREQ_FRAC) ?
                              PHASE_BITS - sog_pkg::FREQ_FRAC : 0;
  localparam int INC_DN     = (PHASE_BITS >= sog_pkg::FREQ_FRAC) ?
                              0 : sog_pkg::FREQ_FRAC - PHASE_BITS;
  localparam int MW         = FREQ_W + INC_UP;
  localparam int DIVW       = MW - INC_DN - sog_pkg::PRESHIFT;
  localparam int DIG        = (DIVW + DIGIT_W - 1) / DIGIT_W;
  localparam int DIVP       = DIG * DIGIT_W;
  localparam int CNT_W      = $clog2(DIG);
  localparam int IPW        = OUT_BITS + FRAC_BITS + 2;

  localparam logic [IPW-1:0]   FRAC_MASK = IPW'((1 << FRAC_BITS) - 1);
  localparam logic [REM_W:0]   DIV_ODD   = (REM_W + 1)'(sog_pkg::ODD_DIV);

  function automatic logic [DEPTH*OUT_BITS-1:0] build_rom();
    logic [DEPTH*OUT_BITS-1:0] bits;
    bits = '0;
    for (int k = 0; k < DEPTH; k++) begin
      bits[k*OUT_BITS +: OUT_BITS] =
        OUT_BITS'(sog_pkg::sine_entry(k, TABLE_ADDR_BITS, OUT_BITS));
    end
    return bits;
  endfunction

  localparam logic [DEPTH*OUT_BITS-1:0] ROM_BITS = build_rom();

  // state and config
  logic [COEFF_W-1:0]       coeff;
  logic signed [FREQ_W-1:0] cur;
  logic [PHASE_BITS-1:0]    phase;

  // glide
  logic signed [TGT_W-1:0]  tgt;
  logic signed [DIFF_W-1:0] tgt_ext;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;
  logic                     dneg;
  logic [DIFF_W-1:0]        prod_hi;
  logic [COEFF_W-1:0]       prod_lo;
  logic [2*COEFF_W-1:0]     lo_full;
  logic [DIFF_W-1:0]        prod_sum;
  logic signed [DIFF_W-1:0] cur_wide;

  // table and interpolation
  logic [TABLE_ADDR_BITS-1:0] idx;
  logic [TABLE_ADDR_BITS-1:0] rd_addr;
  logic [FRAC_BITS-1:0]       frac;
  logic signed [OUT_BITS-1:0] rom_q;
  logic signed [OUT_BITS-1:0] e0;
  logic signed [OUT_BITS:0]   edge_diff;
  logic signed [IPW-1:0]      ip_full;
  logic signed [IPW-1:0]      ip;
  logic signed [IPW-1:0]      ip_adj;
  logic signed [IPW-1:0]      delta;
  logic [OUT_BITS-1:0]        sample_next;

  // increment divider
  logic [FREQ_W-1:0] cur_mag;
  logic [MW-1:0]     m_up;
  logic [DIVP-1:0]   num;
  logic [DIVP-1:0]   quot;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_next;
  logic [REM_W:0]    trial;
  logic [DIGIT_W-1:0] digit;
  logic [CNT_W-1:0]  cnt;

  // glide arithmetic
  assign tgt_ext  = {{(DIFF_W - TGT_W - TGT_SHIFT){tgt[TGT_W-1]}}, tgt, {TGT_SHIFT{1'b0}}};
  assign diff     = {cur[FREQ_W-1], cur} - tgt_ext;
  assign lo_full  = (2*COEFF_W)'(mag[COEFF_W-1:0]) * (2*COEFF_W)'(coeff);
  assign prod_sum = prod_hi + DIFF_W'(prod_lo);
  assign cur_wide = dneg ? tgt_ext - $signed(prod_sum) : tgt_ext + $signed(prod_sum);

  // table addressing
  assign idx     = phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign frac    = phase[ADDR_SHIFT-1 -: FRAC_BITS];
  assign rd_addr = cmd.rd_e1 ? idx + 1'b1 : idx;

  // interpolation, truncated toward zero
  assign edge_diff   = {rom_q[OUT_BITS-1], rom_q} - {e0[OUT_BITS-1], e0};
  assign ip_full     = edge_diff * $signed({1'b0, frac});
  assign ip_adj      = ip[IPW-1] ? ip + $signed(FRAC_MASK) : ip;
  assign delta       = ip_adj >>> FRAC_BITS;
  assign sample_next = e0 + delta[OUT_BITS-1:0];

  // increment numerator
  assign cur_mag = cur[FREQ_W-1] ? FREQ_W'(-cur) : FREQ_W'(cur);
  assign m_up    = MW'(cur_mag) << INC_UP;

  // one radix-256 quotient digit against 375
  always_comb begin
    rem_next = rem;
    digit    = '0;
    trial    = '0;
    for (int b = DIGIT_W - 1; b >= 0; b--) begin
      trial = {rem_next, num[DIVP-DIGIT_W+b]};
      if (trial >= DIV_ODD) begin
        rem_next = REM_W'(trial - DIV_ODD);
        digit[b] = 1'b1;
      end else begin
        rem_next = REM_W'(trial);
      end
    end
  end

  assign status.slot_free = !out_valid || out_ready;
  assign status.div_last  = (cnt == CNT_W'(DIG - 1));

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff     <= sog_pkg::COEFF_RESET;
      cur       <= '0;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        coeff <= cfg_wr_data;
      end
      if (cmd.load && phase_reset) begin
        phase <= '0;
      end else if (cmd.phase_step) begin
        phase <= cur[FREQ_W-1] ? phase - quot[PHASE_BITS-1:0]
                               : phase + quot[PHASE_BITS-1:0];
      end
      if (cmd.emit) begin
        cur       <= FREQ_W'(cur_wide);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt <= target_freq;
    end
    if (cmd.diff) begin
      dneg <= diff[DIFF_W-1];
      mag  <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    end
    if (cmd.mul_hi) begin
      prod_hi <= DIFF_W'(mag[DIFF_W-1:COEFF_W] * coeff);
    end
    if (cmd.mul_lo) begin
      prod_lo <= lo_full[2*COEFF_W-1:COEFF_W];
      ip      <= ip_full;
    end
    if (cmd.rd_e0 || cmd.rd_e1) begin
      rom_q <= ROM_BITS[rd_addr*OUT_BITS +: OUT_BITS];
    end
    if (cmd.rd_e1) begin
      e0 <= rom_q;
    end
    if (cmd.emit) begin
      sample <= sample_next;
    end
    if (cmd.div_load) begin
      num <= DIVP'(m_up >> (INC_DN + sog_pkg::PRESHIFT));
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      num  <= num << DIGIT_W;
      rem  <= rem_next;
      quot <= {quot[DIVP-DIGIT_W-1:0], digit};
      cnt  <= cnt + 1'b1;
    end
  end

endmodule

### hw/rtl/sine_oscillator_with_glide_core.sv
// top level of the sine oscillator with frequency glide
`timescale 1ns / 1ps

// usage
//   in_ch carries one transaction per 48 kHz sample tick: target_freq (signed Hz,
//   8 fraction bits) and phase_reset. out_ch returns exactly one sample transaction
//   per input transaction, in order, as a signed amplitude of OUT_BITS bits.
//   cfg_wr_en/cfg_wr_data write the glide coefficient (unsigned Q0.24); write it
//   only while no sample is in flight.
// sample timing
//   out_ch.valid is set by the emit state, after diff, mul_hi and mul_lo; the sine
//   uses the phase before this tick's advance, after an optional phase reset
// sequencing
//   one input at a time, the next accepted only after the phase advance; the
//   phase increment comes from a long divide by 48000 that yields 8 quotient
//   bits per cycle
// reset
//   rst (synchronous) restores the default coefficient exp(-1/960), zeroes the
//   smoothed frequency and phase, and drops out_ch.valid; in_ch.ready comes up
//   the cycle after rst is released
// stalls
//   the finished sample sits in an output register; the next input is taken
//   while it waits, and the block holds only if that sample is still unclaimed
//   when the next one is ready

module sine_oscillator_with_glide_core #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int OUT_BITS        = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [sog_pkg::COEFF_W-1:0] cfg_wr_data,
  sog_in_if.sink                      in_ch,
  sog_out_if.source                   out_ch
);

  sog_pkg::cmd_t    cmd;
  sog_pkg::status_t status;

  logic                       ready_int;
  logic                       valid_int;
  logic signed [OUT_BITS-1:0] sample_int;

  // sequencer: one transaction at a time through glide, table, divide, phase
  sog_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .status   (status),
    .in_ready (ready_int),
    .cmd      (cmd)
  );

  // arithmetic and the datapath state registers
  sog_datapath #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .OUT_BITS        (OUT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .target_freq (in_ch.target_freq),
    .phase_reset (in_ch.phase_reset),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (out_ch.ready),
    .out_valid   (valid_int),
    .sample      (sample_int)
  );

  assign in_ch.ready   = ready_int;
  assign out_ch.valid  = valid_int;
  assign out_ch.sample = OUT_BITS'(sample_int);

endmodule

### hw/rtl/sog_checker.sv
// port-level checks for the glide oscillator, bound to the top level
`timescale 1ns / 1ps

module sog_checker #(
  parameter int OUT_BITS = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [OUT_BITS-1:0] sample
);

  localparam logic [OUT_BITS-1:0] MOST_NEG = {1'b1, {(OUT_BITS - 1){1'b0}}};

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("sample transaction dropped while stalled");

  // a held result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(sample))
    else $error("sample changed while stalled");

  // one transaction in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second input accepted back to back");

  // interpolated sine stays within the symmetric amplitude
  a_amp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample != MOST_NEG)
    else $error("sample outside amplitude range");

  // reset empties both channels
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("channel active right after reset");

endmodule

bind sine_oscillator_with_glide_core sog_checker #(
  .OUT_BITS (OUT_BITS)
) u_sog_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .sample    (out_ch.sample)
);

### sim/tb_sine_oscillator_with_glide_core.sv
// testbench for the glide oscillator: directed and random ticks, samples checked against a local predictor
`timescale 1ns / 1ps

module tb_sine_oscillator_with_glide_core;

  localparam int     OUT_W         = 16;
  localparam int     LUT_ADDR_W    = 10;
  localparam int     LUT_DEPTH     = 1 << LUT_ADDR_W;
  localparam int     SETTLE_CYCLES = 16;  // divider tail after the last sample leaves
  localparam longint FS_HZ         = 48000;
  localparam longint SINE_AMP      = 32767;
  localparam longint GAIN_Q30      = 652032874;  // cordic gain compensation
  localparam longint HALF_TURN     = 64'sd2147483648;
  localparam longint QUARTER_TURN  = 64'sd1073741824;
  localparam longint FULL_TURN     = 64'sd4294967296;

  localparam logic [sog_pkg::COEFF_W-1:0] GLIDE_DEFAULT = 24'd16759749;  // exp(-1/960)
  localparam logic [sog_pkg::COEFF_W-1:0] GLIDE_NONE    = 24'd0;
  localparam logic [sog_pkg::COEFF_W-1:0] GLIDE_MAX     = 24'hFF_FFFF;

  // atan(2^-i) in units of 2^-32 turn
  localparam longint ARC_TURN [31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1
  };

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_wr_en = 1'b0;
  logic [sog_pkg::COEFF_W-1:0] cfg_wr_data = '0;

  sog_in_if                    in_ch ();
  sog_out_if #(.OUT_BITS(OUT_W)) out_ch ();

  sine_oscillator_with_glide_core #(
    .PHASE_BITS      (32),
    .TABLE_ADDR_BITS (LUT_ADDR_W),
    .OUT_BITS        (OUT_W)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // predictor state: coefficient, smoothed frequency (24 fraction bits), phase
  logic [sog_pkg::COEFF_W-1:0] coeff_q;
  logic signed [39:0]          freq_q;
  logic [31:0]                 phase_q;
  longint                      sine_lut [LUT_DEPTH];

  // samples still owed by the block, oldest first
  logic signed [OUT_W-1:0]     expected_samples [$];

  int gap_pct;    // sender idle chance per cycle, percent
  int stall_pct;  // receiver stall chance per cycle, percent
  int n_fail;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sine lut entry k: integer cordic on the angle folded into [-1/4, 1/4] turn
  function automatic longint lut_value(int k);
    longint ang;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint mag;
    longint v;
    ang = longint'(k) <<< (32 - LUT_ADDR_W);
    if (ang >= HALF_TURN) ang = ang - FULL_TURN;
    if (ang > QUARTER_TURN) begin
      ang = HALF_TURN - ang;
    end else if (ang < -QUARTER_TURN) begin
      ang = -HALF_TURN - ang;
    end
    x = GAIN_Q30;
    y = 0;
    z = ang;
    for (int i = 0; i < 31; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARC_TURN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARC_TURN[i];
      end
    end
    mag = (y < 0) ? -y : y;
    // scale to amplitude, round half away from zero, clamp
    v = (mag * SINE_AMP + (64'sd1 <<< 29)) >>> 30;
    if (v > SINE_AMP) v = SINE_AMP;
    return (y < 0) ? -v : v;
  endfunction

  // one 48 kHz tick: glide, optional phase clear, interpolated sine, phase advance
  function automatic logic signed [OUT_W-1:0] next_sample(input logic signed [23:0] tgt,
                                                          input logic ph_clr);
    longint     tgt_w;
    longint     cur;
    longint     d;
    longint     mag;
    longint     prod;
    longint     e0;
    longint     e1;
    longint     smp;
    longint     inc;
    logic [LUT_ADDR_W-1:0] idx;
    logic [15:0] frac;
    // target widened from 8 to 24 fraction bits
    tgt_w = longint'(tgt) * 65536;
    cur = longint'(freq_q);
    d = cur - tgt_w;
    mag = (d < 0) ? -d : d;
    // c * |d| / 2^24 truncated, split so nothing overflows
    prod = (mag >>> 24) * longint'(coeff_q)
         + (((mag & 64'sd16777215) * longint'(coeff_q)) >>> 24);
    cur = tgt_w + ((d < 0) ? -prod : prod);
    freq_q = cur[39:0];

    if (ph_clr) phase_q = '0;

    // sine taken before the advance
    idx = phase_q[31:32-LUT_ADDR_W];
    frac = phase_q[31-LUT_ADDR_W -: 16];
    e0 = sine_lut[idx];
    e1 = sine_lut[idx + 1'b1];
    smp = e0 + ((e1 - e0) * longint'({1'b0, frac})) / 65536;

    // increment = |cur| * 2^32 / (48000 * 2^24), truncated, sign applied after
    mag = (cur < 0) ? -cur : cur;
    inc = (mag / FS_HZ) * 256 + ((mag % FS_HZ) * 256) / FS_HZ;
    if (cur < 0) begin
      phase_q = phase_q - inc[31:0];
    end else begin
      phase_q = phase_q + inc[31:0];
    end
    return smp[OUT_W-1:0];
  endfunction

  // receiver: ready changes at the falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // sample check on every output transaction
  always @(posedge clk) begin : check_samples
    logic signed [OUT_W-1:0] want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        $error("sample: expected none, actual %0d", out_ch.sample);
        n_fail++;
      end else begin
        want = expected_samples.pop_front();
        if (out_ch.sample !== want) begin
          $error("sample: expected %0d, actual %0d", want, out_ch.sample);
          n_fail++;
        end
      end
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_tick(input logic signed [23:0] tgt, input logic ph_clr);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.target_freq = tgt;
    in_ch.phase_reset = ph_clr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_samples.push_back(next_sample(tgt, ph_clr));
  endtask

  // drop valid, wait for every owed sample, then let the divider finish
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_glide(input logic [sog_pkg::COEFF_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(posedge clk);
    coeff_q = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // mostly in range, some full 24-bit noise, extremes and slow tones
  function automatic logic signed [23:0] pick_target();
    case ($urandom_range(9))
      0: return 24'($urandom());
      1: begin
        case ($urandom_range(3))
          0: return 24'sd6144000;
          1: return -24'sd6144000;
          2: return 24'sh7F_FFFF;
          default: return 24'sh80_0000;
        endcase
      end
      2, 3: return 24'($urandom_range(0, 512000) - 256000);
      default: return 24'($urandom_range(0, 12288000) - 6144000);
    endcase
  endfunction

  function automatic logic [sog_pkg::COEFF_W-1:0] pick_coeff();
    case ($urandom_range(6))
      0: return GLIDE_NONE;
      1: return GLIDE_MAX;
      2: return GLIDE_DEFAULT;
      3: return 24'($urandom_range(0, 1 << 20));
      4: return 24'(GLIDE_MAX - $urandom_range(0, 1 << 16));
      default: return 24'($urandom());
    endcase
  endfunction

  // rails of the target field, plus +-24 kHz, zero and +-1 LSB, under the default glide
  task automatic test_extreme_targets();
    int hz_q8 [8] = '{6144000, 6144000, -6144000, 0, 8388607, -8388608, 1, -1};
    logic clr [8] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
    for (int i = 0; i < 8; i++) send_tick(24'(hz_q8[i]), clr[i]);
  endtask

  // zero coefficient: frequency jumps straight to the target
  task automatic test_no_glide();
    write_glide(GLIDE_NONE);
    send_tick(24'sd25600, 1'b0);
    send_tick(24'sh80_0000, 1'b0);
    send_tick(24'sh7F_FFFF, 1'b0);
    send_tick(24'sd112640, 1'b1);
    send_tick(24'sd0, 1'b0);
  endtask

  // largest coefficient: almost no movement per tick
  task automatic test_slowest_glide();
    write_glide(GLIDE_MAX);
    send_tick(24'sh7F_FFFF, 1'b0);
    send_tick(24'sh80_0000, 1'b1);
    send_tick(24'sd12345, 1'b0);
  endtask

  // negative frequency from phase zero: phase runs backward through the wrap
  task automatic test_backward_phase();
    write_glide(GLIDE_NONE);
    send_tick(-24'sd256000, 1'b1);
    send_tick(-24'sd256000, 1'b0);
    send_tick(-24'sd256000, 1'b0);
    send_tick(24'sh80_0000, 1'b0);
  endtask

  // sender holds off until the block has emptied between ticks
  task automatic test_drain_pause();
    write_glide(GLIDE_DEFAULT);
    for (int i = 0; i < 3; i++) begin
      send_tick(pick_target(), i == 0);
      wait_idle();
    end
  endtask

  // blocks of held targets with random content, new coefficient per block
  task automatic test_random_traffic(input int send_gap, input int recv_stall,
                                     input int n_blocks, input int per_block);
    logic signed [23:0] tgt;
    int hold;
    gap_pct   = send_gap;
    stall_pct = recv_stall;
    for (int b = 0; b < n_blocks; b++) begin
      write_glide(pick_coeff());
      hold = 0;
      for (int i = 0; i < per_block; i++) begin
        if (hold == 0) begin
          tgt  = pick_target();
          hold = $urandom_range(1, 40);
        end
        hold--;
        send_tick(tgt, $urandom_range(15) == 0);
      end
    end
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.target_freq = '0;
    in_ch.phase_reset = 1'b0;
    out_ch.ready      = 1'b0;
    gap_pct   = 0;
    stall_pct = 0;
    n_fail    = 0;
    for (int k = 0; k < LUT_DEPTH; k++) sine_lut[k] = lut_value(k);
    coeff_q = GLIDE_DEFAULT;
    freq_q  = '0;
    phase_q = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_extreme_targets();
    test_no_glide();
    test_slowest_glide();
    test_backward_phase();
    test_drain_pause();
    test_random_traffic(0, 0, 5, 97);
    test_random_traffic(54, 0, 5, 97);
    test_random_traffic(0, 54, 5, 97);
    test_random_traffic(30, 30, 5, 97);

    wait_idle();
    if (n_fail == 0) begin
      $display("sine_oscillator_with_glide_core: match");
    end else begin
      $display("sine_oscillator_with_glide_core: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("sine_oscillator_with_glide_core: mismatch");
    $finish;
  end

endmodule
